// ----- design/mvrm_pkg.sv -----
// Shared types and constants of the resampling mixer.
`default_nettype none
package mvrm_pkg;
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_STOP  = 2'd2;
   localparam logic [1:0] FUNC_FRAME = 2'd3;
   localparam logic [15:0] LOOP_GAIN = 16'd22938;
   localparam logic [7:0] MASTER_RESET = 8'd128;
   // words in the sample store; addresses wrap at this size
   localparam int SAMPLE_WORDS = 65536;

   typedef struct packed {
      logic [1:0]  func;
      logic [2:0]  voice_index;
      logic [15:0] sample_addr;
      logic [15:0] sample_value;
      logic [15:0] frame_count;
      logic [23:0] step_increment;
      logic [31:0] start_phase;
      logic        looping;
      logic        stereo;
      logic [15:0] left_gain;
      logic [15:0] right_gain;
   } cmd_type;

   typedef struct packed {
      logic [15:0] left_out;
      logic [15:0] right_out;
      logic [7:0]  ended_mask;
      logic [7:0]  active_mask;
   } rsp_type;
endpackage
`default_nettype wire

// ----- design/mvrm_cmd_fifo.sv -----
// Command queue between the request side and the mixing engine.
`default_nettype none
module mvrm_cmd_fifo (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  wire mvrm_pkg::cmd_type in_cmd,
   output logic                out_valid,
   input  wire                 out_ready,
   output mvrm_pkg::cmd_type   out_cmd
);
   mvrm_pkg::cmd_type mem_ff [4];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;
   logic push, pop;

   assign in_ready  = (count_ff != 3'd4);
   assign out_valid = (count_ff != 3'd0);
   assign out_cmd   = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // store entry
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_cmd;
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_ff + {2'd0, push} - {2'd0, pop};
      end
   end
endmodule
`default_nettype wire

// ----- design/mvrm_engine.sv -----
// Mixing engine: sample store, voice table and frame sequencer.
`default_nettype none
module mvrm_engine #(
   parameter int VOICES          = 8,
   parameter int PHASE_FRAC_BITS = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire  [7:0]          master_gain,
   input  wire                 cmd_valid,
   output logic                cmd_ready,
   input  wire mvrm_pkg::cmd_type cmd,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output mvrm_pkg::rsp_type   rsp
);
   localparam int AW = $clog2(mvrm_pkg::SAMPLE_WORDS);
   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int FB = PHASE_FRAC_BITS;
   localparam int PW = 32 - FB;
   localparam int MW = (VOICES < 8) ? VOICES : 8;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_VOICE = 4'd1;
   localparam logic [3:0] ST_RD0   = 4'd2;
   localparam logic [3:0] ST_RD1   = 4'd3;
   localparam logic [3:0] ST_RD2   = 4'd4;
   localparam logic [3:0] ST_RD3   = 4'd5;
   localparam logic [3:0] ST_INTL  = 4'd6;
   localparam logic [3:0] ST_INTR  = 4'd7;
   localparam logic [3:0] ST_GAIN  = 4'd8;
   localparam logic [3:0] ST_ACC   = 4'd9;
   localparam logic [3:0] ST_MAST  = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

   logic signed [15:0] store_mem [mvrm_pkg::SAMPLE_WORDS];
   logic [31:0] phase_mem [VOICES];
   logic [15:0] base_mem  [VOICES];
   logic [15:0] len_mem   [VOICES];
   logic [23:0] step_mem  [VOICES];
   logic        loop_mem  [VOICES];
   logic        st_mem    [VOICES];
   logic [15:0] gl_mem    [VOICES];
   logic [15:0] gr_mem    [VOICES];
   logic [VOICES-1:0] active_ff;

   logic [3:0]  state_ff;
   logic [VW-1:0] v_ff;
   logic [7:0]  ended_ff;
   logic [PW-1:0] pos_ff, nxt_ff;
   logic [FB-1:0] frac_ff;
   logic        loop_ff, st_ff;
   logic [15:0] base_ff;
   logic signed [15:0] rd_ff, l0_ff, l1_ff, r0_ff, r1_ff;
   logic signed [16:0] ls_ff, rs_ff;
   logic signed [32:0] pl_ff, pr_ff;
   logic [15:0] gl_ff, gr_ff;
   logic signed [37:0] suml_ff, sumr_ff;
   logic signed [46:0] ml_ff, mr_ff;
   logic rsp_valid_ff;
   mvrm_pkg::rsp_type rsp_ff;
   logic [AW-1:0] rd_addr;
   logic [31:0] cur_phase;
   logic [PW-1:0] cur_pos, cur_nxt;
   logic        last_voice;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;
   assign cur_phase = phase_mem[v_ff];
   assign cur_pos = cur_phase[31:FB];
   assign last_voice = (v_ff == VW'(VOICES - 1));

   function automatic logic signed [15:0] sat16(input logic signed [46:0] x);
      logic signed [39:0] s;
      s = 40'(x >>> 7);
      if (s > 40'sd32767) return 16'sh7fff;
      if (s < -40'sd32768) return 16'sh8000;
      return s[15:0];
   endfunction

   // next frame index
   always_comb begin
      if ({{(32-PW){1'b0}}, pos_ff} + 32'd1 >= {16'd0, len_mem[v_ff]})
         cur_nxt = loop_ff ? '0 : pos_ff;
      else
         cur_nxt = pos_ff + PW'(1);
   end

   // word address of the current read
   always_comb begin
      logic [31:0] off;
      case (state_ff)
         ST_RD0:  off = st_ff ? 32'({pos_ff, 1'b0}) : 32'(pos_ff);
         ST_RD1:  off = st_ff ? 32'({nxt_ff, 1'b0}) : 32'(nxt_ff);
         ST_RD2:  off = 32'({pos_ff, 1'b1});
         default: off = 32'({nxt_ff, 1'b1});
      endcase
      rd_addr = AW'(32'(base_ff) + off);
   end

   // register store reads
   always_ff @(posedge clock) begin
      rd_ff <= store_mem[rd_addr];
      if (state_ff == ST_IDLE && cmd_valid && cmd_ready && cmd.func == mvrm_pkg::FUNC_WRITE)
         store_mem[AW'(cmd.sample_addr)] <= cmd.sample_value;
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         active_ff <= '0;
         rsp_valid_ff <= 1'b0;
         v_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  case (cmd.func)
                     mvrm_pkg::FUNC_START: begin
                        if (32'(cmd.voice_index) < VOICES) begin
                           if (cmd.frame_count == 16'd0) begin
                              active_ff[VW'(cmd.voice_index)] <= 1'b0;
                           end else begin
                              base_mem[VW'(cmd.voice_index)] <= cmd.sample_addr;
                              len_mem[VW'(cmd.voice_index)] <= cmd.frame_count;
                              step_mem[VW'(cmd.voice_index)] <= cmd.step_increment;
                              phase_mem[VW'(cmd.voice_index)] <= cmd.start_phase;
                              loop_mem[VW'(cmd.voice_index)] <= cmd.looping;
                              st_mem[VW'(cmd.voice_index)] <= cmd.stereo;
                              gl_mem[VW'(cmd.voice_index)] <= cmd.left_gain;
                              gr_mem[VW'(cmd.voice_index)] <= cmd.right_gain;
                              active_ff[VW'(cmd.voice_index)] <= 1'b1;
                           end
                        end
                     end
                     mvrm_pkg::FUNC_STOP: begin
                        if (32'(cmd.voice_index) < VOICES)
                           active_ff[VW'(cmd.voice_index)] <= 1'b0;
                     end
                     mvrm_pkg::FUNC_FRAME: begin
                        v_ff <= '0;
                        ended_ff <= '0;
                        suml_ff <= '0;
                        sumr_ff <= '0;
                        state_ff <= ST_VOICE;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_VOICE: begin
               loop_ff <= loop_mem[v_ff];
               st_ff <= st_mem[v_ff];
               base_ff <= base_mem[v_ff];
               gl_ff <= gl_mem[v_ff];
               gr_ff <= gr_mem[v_ff];
               if (!active_ff[v_ff]) begin
                  if (last_voice) state_ff <= ST_MAST;
                  else v_ff <= v_ff + VW'(1);
               end else if ({16'd0, cur_pos} >= {16'd0, len_mem[v_ff]}) begin
                  if (loop_mem[v_ff]) begin
                     pos_ff <= '0;
                     frac_ff <= '0;
                     phase_mem[v_ff] <= '0;
                     state_ff <= ST_RD0;
                  end else begin
                     active_ff[v_ff] <= 1'b0;
                     if (32'(v_ff) < 8) ended_ff[3'(v_ff)] <= 1'b1;
                     if (last_voice) state_ff <= ST_MAST;
                     else v_ff <= v_ff + VW'(1);
                  end
               end else begin
                  pos_ff <= cur_pos;
                  frac_ff <= cur_phase[FB-1:0];
                  state_ff <= ST_RD0;
               end
            end
            ST_RD0: begin
               nxt_ff <= cur_nxt;
               state_ff <= ST_RD1;
            end
            ST_RD1: begin
               l0_ff <= rd_ff;
               state_ff <= ST_RD2;
            end
            ST_RD2: begin
               l1_ff <= rd_ff;
               state_ff <= ST_RD3;
            end
            ST_RD3: begin
               r0_ff <= st_ff ? rd_ff : l0_ff;
               state_ff <= ST_INTL;
            end
            ST_INTL: begin
               r1_ff <= st_ff ? rd_ff : l1_ff;
               ls_ff <= 17'(l0_ff) + 17'((34'(l1_ff - 17'(l0_ff)) *
                        $signed({1'b0, frac_ff})) >>> FB);
               if (loop_ff) gl_ff <= 16'((32'(gl_ff) * 32'(mvrm_pkg::LOOP_GAIN)) >> 16);
               state_ff <= ST_INTR;
            end
            ST_INTR: begin
               rs_ff <= 17'(r0_ff) + 17'((34'(r1_ff - 17'(r0_ff)) *
                        $signed({1'b0, frac_ff})) >>> FB);
               if (loop_ff) gr_ff <= 16'((32'(gr_ff) * 32'(mvrm_pkg::LOOP_GAIN)) >> 16);
               state_ff <= ST_GAIN;
            end
            ST_GAIN: begin
               pl_ff <= 33'(ls_ff) * $signed({17'd0, gl_ff});
               pr_ff <= 33'(rs_ff) * $signed({17'd0, gr_ff});
               phase_mem[v_ff] <= cur_phase + 32'(step_mem[v_ff]);
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               suml_ff <= suml_ff + 38'(pl_ff >>> 16);
               sumr_ff <= sumr_ff + 38'(pr_ff >>> 16);
               if (last_voice) state_ff <= ST_MAST;
               else begin
                  v_ff <= v_ff + VW'(1);
                  state_ff <= ST_VOICE;
               end
            end
            ST_MAST: begin
               ml_ff <= 47'(suml_ff) * $signed({39'd0, master_gain});
               mr_ff <= 47'(sumr_ff) * $signed({39'd0, master_gain});
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               // hold the finished frame until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.left_out <= sat16(ml_ff);
                  rsp_ff.right_out <= sat16(mr_ff);
                  rsp_ff.ended_mask <= ended_ff;
                  rsp_ff.active_mask <= 8'(active_ff[MW-1:0]);
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- design/multi_voice_resampling_mixer_top.sv -----
// Top level of the multi-voice resampling mixer.
// Beats wait in a 4-deep command queue; write, start and stop are done in the idle state.
// A frame visits every voice: an active one runs VOICE, RD0-RD3, INTL, INTR, GAIN and ACC,
// an idle or ending one VOICE only, then MAST and OUT; one frame is worked at a time.
// A result waiting at the output holds the engine in OUT; the queue takes beats until full.
// Synchronous active-high reset clears voices, queue and sets master gain to 128;
// the sample store and voice parameters are undefined until written.
`default_nettype none
module multi_voice_resampling_mixer_top #(
   parameter int VOICES          = 8,
   parameter int PHASE_FRAC_BITS = 16
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // func
   input  wire  [1:0]   req_tuser,
   // voice_index, sample_addr, sample_value, frame_count, step_increment,
   // start_phase, looping, stereo, left_gain, right_gain, zero pad
   input  wire  [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // left_out, right_out, ended_mask, active_mask
   output logic [47:0]  rsp_tdata,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [7:0]   csr_data
);
   logic [7:0] master_gain_ff;
   mvrm_pkg::cmd_type in_cmd, q_cmd;
   mvrm_pkg::rsp_type rsp;
   logic q_valid, q_ready;

   assign csr_ready = 1'b1;

   // hold master gain
   always_ff @(posedge clock) begin
      if (reset) master_gain_ff <= mvrm_pkg::MASTER_RESET;
      else if (csr_valid && csr_ready) master_gain_ff <= csr_data;
   end

   // unpack request beat
   always_comb begin
      in_cmd.func           = req_tuser;
      in_cmd.voice_index    = req_tdata[2:0];
      in_cmd.sample_addr    = req_tdata[18:3];
      in_cmd.sample_value   = req_tdata[34:19];
      in_cmd.frame_count    = req_tdata[50:35];
      in_cmd.step_increment = req_tdata[74:51];
      in_cmd.start_phase    = req_tdata[106:75];
      in_cmd.looping        = req_tdata[107];
      in_cmd.stereo         = req_tdata[108];
      in_cmd.left_gain      = req_tdata[124:109];
      in_cmd.right_gain     = req_tdata[140:125];
   end

   mvrm_cmd_fifo u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   mvrm_engine #(
      .VOICES(VOICES), .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
   ) u_engine (
      .clock(clock), .reset(reset), .master_gain(master_gain_ff),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp(rsp)
   );

   assign rsp_tdata = {rsp.active_mask, rsp.ended_mask, rsp.right_out, rsp.left_out};
endmodule
`default_nettype wire
